/* sv/bfsp_pkg.sv */
// Package for the banded fan speed PWM core: field widths, register and
// operation codes, speed bands, reset values and the duty lookup table.
// Depends on nothing; every other file imports it.
`default_nettype none

package bfsp_pkg;

  // Default widths of the temperature fields and of the PWM counter.
  localparam int TEMP_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF = 16;

  // Thresholds never narrower than this, so that their reset values fit.
  localparam int THR_MIN_BITS = 12;

  // Speed and duty widths.
  localparam int SPEED_BITS = 7;
  localparam int MANUAL_BITS = 8;
  localparam int DUTY_BITS = 10;
  localparam int OP_BITS = 2;

  // Configuration port shape.
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_OFF_BELOW  = 3'd0,
    REG_LOW_BAND   = 3'd1,
    REG_MID_BAND   = 3'd2,
    REG_HIGH_BAND  = 3'd3,
    REG_PWM_TOP    = 3'd4,
    REG_MIN_SPEED  = 3'd5
  } cfg_reg_t;

  // Operation codes of an input item.
  typedef enum logic [OP_BITS-1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_MANUAL = 2'd2
  } op_t;

  // Speed bands in percent.
  localparam logic [SPEED_BITS-1:0] SPEED_OFF  = 7'd0;
  localparam logic [SPEED_BITS-1:0] SPEED_LOW  = 7'd25;
  localparam logic [SPEED_BITS-1:0] SPEED_MID  = 7'd50;
  localparam logic [SPEED_BITS-1:0] SPEED_FULL = 7'd100;

  // Reset values of the configuration registers.
  localparam int RST_OFF_BELOW = 416;
  localparam int RST_LOW_BAND  = 480;
  localparam int RST_MID_BAND  = 560;
  localparam int RST_HIGH_BAND = 640;
  localparam int RST_PWM_TOP   = 320;
  localparam logic [SPEED_BITS-1:0] RST_MIN_SPEED = 7'd4;

  // Reset values of the working state.
  localparam int RST_COMPARE = 12;
  localparam logic [SPEED_BITS-1:0] RST_APPLIED = 7'd4;
  localparam logic [SPEED_BITS-1:0] RST_LAST_REQ = 7'd0;

  // Duty per speed percent: floor(speed * 1023 / 100), full scale above 100.
  localparam int DUTY_ENTRIES = 1 << SPEED_BITS;
  typedef logic [DUTY_BITS-1:0] duty_tab_t [0:DUTY_ENTRIES-1];

  function automatic duty_tab_t build_duty_tab();
    duty_tab_t tab;
    for (int i = 0; i < DUTY_ENTRIES; i++) begin
      if (i <= 100) begin
        tab[i] = DUTY_BITS'((i * 1023) / 100);
      end else begin
        tab[i] = DUTY_BITS'(1023);
      end
    end
    return tab;
  endfunction

  localparam duty_tab_t DUTY_TAB = build_duty_tab();

endpackage

`default_nettype wire

/* sv/bfsp_if.sv */
// Channel interfaces of the banded fan speed PWM core: input items, result
// items and configuration writes, each with valid and ready.
// Depends on bfsp_pkg.
`default_nettype none

interface bfsp_in_if
  import bfsp_pkg::*;
#(
  parameter int TEMP_BITS = TEMP_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [OP_BITS-1:0]          op;
  logic signed [TEMP_BITS-1:0] temp_a;
  logic signed [TEMP_BITS-1:0] temp_b;
  logic signed [TEMP_BITS-1:0] temp_c;
  logic [MANUAL_BITS-1:0]      manual_speed;

  modport source (output valid, op, temp_a, temp_b, temp_c, manual_speed, input ready);
  modport sink (input valid, op, temp_a, temp_b, temp_c, manual_speed, output ready);
endinterface

interface bfsp_out_if
  import bfsp_pkg::*;
#(
  parameter int TEMP_BITS = TEMP_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic                        pwm_level;
  logic [SPEED_BITS-1:0]       speed_pct;
  logic signed [TEMP_BITS-1:0] peak_temp;
  logic [COUNT_BITS-1:0]       compare_value;

  modport source (output valid, pwm_level, speed_pct, peak_temp, compare_value, input ready);
  modport sink (input valid, pwm_level, speed_pct, peak_temp, compare_value, output ready);
endinterface

interface bfsp_cfg_if
  import bfsp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/banded_fan_speed_pwm_core.sv */
// Banded fan speed PWM core: stepped fan curve feeding an up/down PWM counter.
// Depends on bfsp_pkg and the channel interfaces in bfsp_if.sv.
//
// Usage
//   in_ch carries one item per transfer: a PWM tick, a temperature sample
//   (three sensors) or a manual speed set, chosen by op. Every item gives
//   exactly one result on out_ch: the PWM level, the applied speed, the last
//   maximum temperature and the pending compare value, all after the item.
//   cfg_ch writes the four thresholds and the two settings; it is always ready and
//   should only be used while no item is in flight.
// Datapath and throughput
//   An item is registered on entry and its result is offered from the result
//   register. One item per cycle is sustained while out_ch accepts results:
//   the whole update (three-way maximum, band compares, duty lookup and one
//   pwm_top by duty multiply) sits between the input register and the result
//   register, and the counter state loops back through its own registers.
// Reset
//   rst_n is synchronous and active low. It restores the default curve,
//   top 320, compare 12 and speed 4 percent, and empties both registers.
// Stalls
//   While out_ch is held off, the result waits in the output register and
//   one further item may wait in the input register; in_ch.ready then drops.
`default_nettype none

module banded_fan_speed_pwm_core
  import bfsp_pkg::*;
#(
  parameter int TEMP_BITS = TEMP_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bfsp_in_if.sink     in_ch,
  bfsp_out_if.source  out_ch,
  bfsp_cfg_if.sink    cfg_ch
);

  localparam int THR_BITS = (TEMP_BITS > THR_MIN_BITS) ? TEMP_BITS : THR_MIN_BITS;
  localparam int PROD_BITS = COUNT_BITS + DUTY_BITS;

  // Configuration registers.
  logic signed [THR_BITS-1:0] off_below_r;
  logic signed [THR_BITS-1:0] low_band_r;
  logic signed [THR_BITS-1:0] mid_band_r;
  logic signed [THR_BITS-1:0] high_band_r;
  logic [COUNT_BITS-1:0]      pwm_top_r;
  logic [SPEED_BITS-1:0]      min_speed_r;

  // Input register.
  logic                        in_vld_r;
  logic [OP_BITS-1:0]          op_r;
  logic signed [TEMP_BITS-1:0] temp_a_r;
  logic signed [TEMP_BITS-1:0] temp_b_r;
  logic signed [TEMP_BITS-1:0] temp_c_r;
  logic [MANUAL_BITS-1:0]      manual_r;

  // Working state.
  logic [COUNT_BITS-1:0]       pwm_count_r, pwm_count_nxt;
  logic                        counting_down_r, counting_down_nxt;
  logic [COUNT_BITS-1:0]       active_cmp_r, active_cmp_nxt;
  logic [COUNT_BITS-1:0]       pending_cmp_r, pending_cmp_nxt;
  logic                        req_valid_r, req_valid_nxt;
  logic [SPEED_BITS-1:0]       last_req_r, last_req_nxt;
  logic [SPEED_BITS-1:0]       applied_r, applied_nxt;
  logic signed [TEMP_BITS-1:0] last_max_r, last_max_nxt;

  // Output register.
  logic                        out_vld_r;
  logic                        pwm_level_r;
  logic [SPEED_BITS-1:0]       speed_r;
  logic signed [TEMP_BITS-1:0] peak_temp_r;
  logic [COUNT_BITS-1:0]       compare_r;

  // Request path signals.
  logic                        req_go;
  logic [SPEED_BITS-1:0]       req_speed;
  logic [SPEED_BITS-1:0]       min_clamped;
  logic [SPEED_BITS-1:0]       new_speed;
  logic [DUTY_BITS-1:0]        duty;
  logic [PROD_BITS-1:0]        product;
  logic signed [TEMP_BITS-1:0] temp_max;
  logic signed [THR_BITS-1:0]  temp_max_ext;
  logic                        tick_down;

  logic in_xfer;
  logic adv;

  // Handshake: the processing stage advances when it holds an item and the
  // output register is empty or being emptied.
  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_vld_r;
  assign out_ch.pwm_level     = pwm_level_r;
  assign out_ch.speed_pct     = speed_r;
  assign out_ch.peak_temp     = peak_temp_r;
  assign out_ch.compare_value = compare_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_below_r <= THR_BITS'(RST_OFF_BELOW);
      low_band_r  <= THR_BITS'(RST_LOW_BAND);
      mid_band_r  <= THR_BITS'(RST_MID_BAND);
      high_band_r <= THR_BITS'(RST_HIGH_BAND);
      pwm_top_r   <= COUNT_BITS'(RST_PWM_TOP);
      min_speed_r <= RST_MIN_SPEED;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_OFF_BELOW: off_below_r <= THR_BITS'($signed(cfg_ch.data[TEMP_BITS-1:0]));
        REG_LOW_BAND:  low_band_r  <= THR_BITS'($signed(cfg_ch.data[TEMP_BITS-1:0]));
        REG_MID_BAND:  mid_band_r  <= THR_BITS'($signed(cfg_ch.data[TEMP_BITS-1:0]));
        REG_HIGH_BAND: high_band_r <= THR_BITS'($signed(cfg_ch.data[TEMP_BITS-1:0]));
        REG_PWM_TOP:   pwm_top_r   <= cfg_ch.data[COUNT_BITS-1:0];
        REG_MIN_SPEED: min_speed_r <= cfg_ch.data[SPEED_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: valid flag under reset, payload captured on transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_ch.op;
      temp_a_r <= in_ch.temp_a;
      temp_b_r <= in_ch.temp_b;
      temp_c_r <= in_ch.temp_c;
      manual_r <= in_ch.manual_speed;
    end
  end

  // Maximum of the three sensors, sensor b winning ties.
  always_comb begin
    temp_max = temp_b_r;
    if (temp_a_r > temp_max) begin
      temp_max = temp_a_r;
    end
    if (temp_c_r > temp_max) begin
      temp_max = temp_c_r;
    end
    temp_max_ext = THR_BITS'(temp_max);
  end

  // Item decode: counter step, band selection or manual request.
  always_comb begin
    pwm_count_nxt     = pwm_count_r;
    counting_down_nxt = counting_down_r;
    active_cmp_nxt    = active_cmp_r;
    last_max_nxt      = last_max_r;
    req_go            = 1'b0;
    req_speed         = SPEED_OFF;
    tick_down         = counting_down_r;

    case (op_r)
      OP_TICK: begin
        // Turn at or above the top while counting up, turn again at zero.
        if (!tick_down && (pwm_count_r >= pwm_top_r)) begin
          tick_down = 1'b1;
        end
        if (tick_down && (pwm_count_r == '0)) begin
          tick_down = 1'b0;
        end
        if (tick_down) begin
          pwm_count_nxt = pwm_count_r - COUNT_BITS'(1);
        end else if (pwm_count_r < pwm_top_r) begin
          pwm_count_nxt = pwm_count_r + COUNT_BITS'(1);
        end
        counting_down_nxt = tick_down;
        // The pending compare takes effect at the bottom of the count.
        if (pwm_count_nxt == '0) begin
          active_cmp_nxt = pending_cmp_r;
        end
      end
      OP_SAMPLE: begin
        // Later band tests override earlier ones; the hold band requests nothing.
        if (temp_max != last_max_r) begin
          last_max_nxt = temp_max;
          if (temp_max_ext < off_below_r) begin
            req_go    = 1'b1;
            req_speed = SPEED_OFF;
          end
          if ((temp_max_ext > low_band_r) && (temp_max_ext <= mid_band_r)) begin
            req_go    = 1'b1;
            req_speed = SPEED_LOW;
          end
          if ((temp_max_ext > mid_band_r) && (temp_max_ext <= high_band_r)) begin
            req_go    = 1'b1;
            req_speed = SPEED_MID;
          end
          if (temp_max_ext > high_band_r) begin
            req_go    = 1'b1;
            req_speed = SPEED_FULL;
          end
        end
      end
      OP_MANUAL: begin
        req_go = 1'b1;
        if (manual_r > MANUAL_BITS'(SPEED_FULL)) begin
          req_speed = SPEED_FULL;
        end else begin
          req_speed = manual_r[SPEED_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Speed request: raise to the minimum, look up the duty, scale by the top.
  always_comb begin
    min_clamped = (min_speed_r > SPEED_FULL) ? SPEED_FULL : min_speed_r;
    new_speed   = (req_speed <= min_clamped) ? min_clamped : req_speed;
    duty        = DUTY_TAB[new_speed];
    product     = PROD_BITS'(pwm_top_r) * PROD_BITS'(duty);

    req_valid_nxt   = req_valid_r;
    last_req_nxt    = last_req_r;
    applied_nxt     = applied_r;
    pending_cmp_nxt = pending_cmp_r;
    // A repeat of the last request leaves everything as it is.
    if (req_go && !(req_valid_r && (req_speed == last_req_r))) begin
      req_valid_nxt   = 1'b1;
      last_req_nxt    = req_speed;
      applied_nxt     = new_speed;
      pending_cmp_nxt = product[PROD_BITS-1:DUTY_BITS];
    end
  end

  // Working state, updated once for each item that leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_count_r     <= '0;
      counting_down_r <= 1'b0;
      active_cmp_r    <= COUNT_BITS'(RST_COMPARE);
      pending_cmp_r   <= COUNT_BITS'(RST_COMPARE);
      req_valid_r     <= 1'b1;
      last_req_r      <= RST_LAST_REQ;
      applied_r       <= RST_APPLIED;
      last_max_r      <= '0;
    end else if (adv) begin
      pwm_count_r     <= pwm_count_nxt;
      counting_down_r <= counting_down_nxt;
      active_cmp_r    <= active_cmp_nxt;
      pending_cmp_r   <= pending_cmp_nxt;
      req_valid_r     <= req_valid_nxt;
      last_req_r      <= last_req_nxt;
      applied_r       <= applied_nxt;
      last_max_r      <= last_max_nxt;
    end
  end

  // Output register: the status after the item just processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pwm_level_r <= (pwm_count_nxt < active_cmp_nxt);
      speed_r     <= applied_nxt;
      peak_temp_r <= last_max_nxt;
      compare_r   <= pending_cmp_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for banded_fan_speed_pwm_core: drives ticks, samples and manual sets
// across a range of fan curves, and checks every status against an in-bench fan curve tracker.
// Depends on bfsp_pkg, the channel interfaces in bfsp_if.sv and the core itself.
`timescale 1ns / 1ps

module tb_top;
  import bfsp_pkg::*;

  localparam int TB = TEMP_BITS_DEF;
  localparam int CB = COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 85;
  localparam int LONG_HOLD = 200;

  // Codes outside the package enums that the fields still allow.
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OP_BITS-1:0]     op;
    logic [TB-1:0]          temp_a;
    logic [TB-1:0]          temp_b;
    logic [TB-1:0]          temp_c;
    logic [MANUAL_BITS-1:0] manual_speed;
  } fan_cmd_t;

  typedef struct packed {
    logic                  pwm_level;
    logic [SPEED_BITS-1:0] speed_pct;
    logic [TB-1:0]         peak_temp;
    logic [CB-1:0]         compare_value;
  } fan_status_t;

  function automatic int sx(logic [TB-1:0] v);
    return int'($signed(v));
  endfunction

  // Tracks the fan curve, the applied speed and the PWM counter, and keeps
  // the statuses that accepted items are due to produce.
  class fan_status_board;
    logic [TB-1:0]         thr_off, thr_low, thr_mid, thr_high;
    logic [CB-1:0]         top;
    logic [SPEED_BITS-1:0] min_speed;
    logic [CB-1:0]         count, live_cmp, next_cmp;
    bit                    down, req_seen;
    logic [SPEED_BITS-1:0] last_req, applied;
    logic [TB-1:0]         last_max;
    fan_status_t           expected_status_q[$];
    int                    mismatches;

    function new();
      thr_off = TB'(RST_OFF_BELOW);
      thr_low = TB'(RST_LOW_BAND);
      thr_mid = TB'(RST_MID_BAND);
      thr_high = TB'(RST_HIGH_BAND);
      top = CB'(RST_PWM_TOP);
      min_speed = RST_MIN_SPEED;
      count = '0;
      down = 1'b0;
      live_cmp = CB'(RST_COMPARE);
      next_cmp = CB'(RST_COMPARE);
      req_seen = 1'b1;
      last_req = RST_LAST_REQ;
      applied = RST_APPLIED;
      last_max = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_OFF_BELOW: thr_off = data[TB-1:0];
        REG_LOW_BAND:  thr_low = data[TB-1:0];
        REG_MID_BAND:  thr_mid = data[TB-1:0];
        REG_HIGH_BAND: thr_high = data[TB-1:0];
        REG_PWM_TOP:   top = data[CB-1:0];
        REG_MIN_SPEED: min_speed = data[SPEED_BITS-1:0];
        default: ;
      endcase
    endfunction

    // A repeated request is dropped; otherwise the speed is raised to the
    // minimum and turned into the compare value that waits for the counter.
    function void request_speed(int req);
      int floor_pct, pct, duty;
      if (req_seen && req == int'(last_req)) return;
      last_req = SPEED_BITS'(req);
      req_seen = 1'b1;
      floor_pct = int'(min_speed) > int'(SPEED_FULL) ? int'(SPEED_FULL) : int'(min_speed);
      pct = req <= floor_pct ? floor_pct : req;
      applied = SPEED_BITS'(pct);
      duty = pct * 1023 / 100;
      next_cmp = CB'((int'(top) * duty) >> DUTY_BITS);
    endfunction

    function void accept_item(fan_cmd_t c);
      int peak, band;
      bit change;
      fan_status_t s;
      case (c.op)
        OP_TICK: begin
          if (!down && count >= top) down = 1'b1;
          if (down && count == '0) down = 1'b0;
          if (down) count = count - 1'b1;
          else if (count < top) count = count + 1'b1;
          if (count == '0) live_cmp = next_cmp;
        end
        OP_SAMPLE: begin
          peak = sx(c.temp_b);
          if (sx(c.temp_a) > peak) peak = sx(c.temp_a);
          if (sx(c.temp_c) > peak) peak = sx(c.temp_c);
          if (peak != sx(last_max)) begin
            last_max = TB'(peak);
            change = 1'b0;
            band = 0;
            // Later bands win, which matters when the thresholds are out of order.
            if (peak < sx(thr_off)) begin
              band = SPEED_OFF;
              change = 1'b1;
            end
            if (peak > sx(thr_low) && peak <= sx(thr_mid)) begin
              band = SPEED_LOW;
              change = 1'b1;
            end
            if (peak > sx(thr_mid) && peak <= sx(thr_high)) begin
              band = SPEED_MID;
              change = 1'b1;
            end
            if (peak > sx(thr_high)) begin
              band = SPEED_FULL;
              change = 1'b1;
            end
            if (change) request_speed(band);
          end
        end
        OP_MANUAL: begin
          if (int'(c.manual_speed) > int'(SPEED_FULL)) request_speed(SPEED_FULL);
          else request_speed(int'(c.manual_speed));
        end
        default: ;
      endcase
      s.pwm_level = (count < live_cmp);
      s.speed_pct = applied;
      s.peak_temp = last_max;
      s.compare_value = next_cmp;
      expected_status_q.push_back(s);
    endfunction

    function void check_status(fan_status_t got);
      fan_status_t want;
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected status: pwm %0d speed %0d max %0d cmp %0d",
                   $time, got.pwm_level, got.speed_pct, sx(got.peak_temp),
                   got.compare_value);
        return;
      end
      want = expected_status_q.pop_front();
      if (got.pwm_level !== want.pwm_level || got.speed_pct !== want.speed_pct ||
          got.peak_temp !== want.peak_temp || got.compare_value !== want.compare_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: expected pwm %0d speed %0d max %0d cmp %0d, %s",
                   $time, want.pwm_level, want.speed_pct, sx(want.peak_temp),
                   want.compare_value,
                   $sformatf("got pwm %0d speed %0d max %0d cmp %0d", got.pwm_level,
                             got.speed_pct, sx(got.peak_temp), got.compare_value));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned cycle_count = 0;
  fan_status_board board;
  bit feed_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int hold_cycles = 0;
  int last_peak = 0;

  bfsp_in_if  in_ch();
  bfsp_out_if out_ch();
  bfsp_cfg_if cfg_ch();

  banded_fan_speed_pwm_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  // Cycle limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("banded_fan_speed_pwm_core verification failed");
      $finish;
    end
  end

  // Watch every channel and feed each transfer to the tracker.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        board.accept_item(fan_cmd_t'({in_ch.op, in_ch.temp_a, in_ch.temp_b, in_ch.temp_c,
                                      in_ch.manual_speed}));
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
        board.write_reg(cfg_ch.index, cfg_ch.data);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        board.check_status(fan_status_t'({out_ch.pwm_level, out_ch.speed_pct, out_ch.peak_temp,
                                          out_ch.compare_value}));
    end
  end

  // Status receiver: a random stall before each transfer, or a long hold on request.
  initial begin : status_sink
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = sink_stalls ? $urandom_range(0, 16) : 0;
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  function automatic fan_cmd_t mk(logic [OP_BITS-1:0] op, int a, int b, int c, int man);
    fan_cmd_t cmd;
    cmd.op = op;
    cmd.temp_a = TB'(a);
    cmd.temp_b = TB'(b);
    cmd.temp_c = TB'(c);
    cmd.manual_speed = MANUAL_BITS'(man);
    return cmd;
  endfunction

  function automatic int near(logic [TB-1:0] thr);
    return sx(thr) + int'($urandom_range(0, 6)) - 3;
  endfunction

  function automatic int under(int peak);
    int v;
    v = peak - int'($urandom_range(0, 300));
    return v < -2048 ? -2048 : v;
  endfunction

  // Mostly ticks; samples cluster round the thresholds so every band is crossed.
  function automatic fan_cmd_t random_cmd();
    fan_cmd_t c;
    int roll, peak;
    c = mk(OP_TICK, $urandom, $urandom, $urandom, $urandom);
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      c.op = OP_TICK;
    end else if (roll < 82) begin
      c.op = OP_SAMPLE;
      case ($urandom_range(0, 7))
        0: peak = near(board.thr_off);
        1: peak = near(board.thr_low);
        2: peak = near(board.thr_mid);
        3: peak = near(board.thr_high);
        4: peak = sx(TB'($urandom));
        5: peak = last_peak;
        default: peak = int'($urandom_range(0, 2880)) - 880;
      endcase
      if (peak > 2047) peak = 2047;
      last_peak = peak;
      c.temp_a = TB'(under(peak));
      c.temp_b = TB'(under(peak));
      c.temp_c = TB'(under(peak));
      case ($urandom_range(0, 2))
        0: c.temp_a = TB'(peak);
        1: c.temp_b = TB'(peak);
        default: c.temp_c = TB'(peak);
      endcase
    end else if (roll < 97) begin
      c.op = OP_MANUAL;
      c.manual_speed = ($urandom_range(0, 3) == 0) ? MANUAL_BITS'($urandom_range(0, 255))
                                                    : MANUAL_BITS'($urandom_range(0, 110));
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  // One input transfer, after a random gap when gaps are enabled.
  task automatic send_cmd(input fan_cmd_t c);
    int gap;
    gap = feed_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= c.op;
    in_ch.temp_a <= c.temp_a;
    in_ch.temp_b <= c.temp_b;
    in_ch.temp_c <= c.temp_c;
    in_ch.manual_speed <= c.manual_speed;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Leaves valid high so that back-to-back writes never lower and raise it in one step.
  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  // Stop offering items and wait until every status has come back.
  task automatic wait_all_status();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.expected_status_q.size() != 0);
  endtask

  // Fan curve for one phase: ordered, scrambled and extreme thresholds,
  // tops from zero to full scale and minimum speeds past 100.
  task automatic set_curve(input int p);
    int tq[$];
    logic [CB-1:0] top_val;
    logic [SPEED_BITS-1:0] min_val;
    repeat (4) tq.push_back(int'($urandom_range(0, 2880)) - 880);
    if (p % 4 != 1) tq.sort();
    if (p % 4 == 1) begin
      foreach (tq[i]) tq[i] = sx(TB'($urandom));
    end
    if (p == 3) tq = '{-2048, -2048, 2047, 2047};
    if (p == 7) tq = '{2047, -880, 2000, -2048};
    case (p)
      0: top_val = CB'(RST_PWM_TOP);
      1: top_val = '0;
      2: top_val = 1;
      3: top_val = '1;
      4: top_val = 3;
      5: top_val = CB'($urandom_range(2, 64));
      6: top_val = 10;
      7: top_val = CB'($urandom_range(1, 1000));
      8: top_val = 2;
      9: top_val = 65534;
      10: top_val = CB'($urandom_range(2, 40));
      default: top_val = CB'(RST_PWM_TOP);
    endcase
    case (p)
      0: min_val = 0;
      1: min_val = 100;
      2: min_val = '1;
      3: min_val = RST_MIN_SPEED;
      4: min_val = 101;
      5: min_val = SPEED_BITS'($urandom);
      6: min_val = 50;
      7: min_val = 0;
      8: min_val = SPEED_BITS'($urandom_range(0, 100));
      9: min_val = 25;
      10: min_val = '1;
      default: min_val = RST_MIN_SPEED;
    endcase
    write_cfg(REG_OFF_BELOW, {4'($urandom), TB'(tq[0])});
    write_cfg(REG_LOW_BAND, {4'($urandom), TB'(tq[1])});
    write_cfg(REG_MID_BAND, {4'($urandom), TB'(tq[2])});
    write_cfg(REG_HIGH_BAND, {4'($urandom), TB'(tq[3])});
    write_cfg(REG_PWM_TOP, top_val);
    write_cfg(REG_MIN_SPEED, {9'($urandom), min_val});
    if (p == 5) begin
      write_cfg(REG_SPARE_LO, CFG_DATA_BITS'($urandom));
      write_cfg(REG_SPARE_HI, CFG_DATA_BITS'($urandom));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    bit saved_gaps;
    board = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_TICK;
    in_ch.temp_a <= '0;
    in_ch.temp_b <= '0;
    in_ch.temp_c <= '0;
    in_ch.manual_speed <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_OFF_BELOW;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items on the reset curve: every band, edges at the off, low and high thresholds,
    // an unchanged maximum, repeated and saturated manual requests, and the unused operation.
    send_cmd(mk(OP_TICK, 0, 0, 0, 0));
    send_cmd(mk(OP_SAMPLE, 2000, -880, -2048, 0));
    send_cmd(mk(OP_SAMPLE, -880, 2000, 0, 0));
    send_cmd(mk(OP_SAMPLE, -2048, -2048, -2048, 0));
    send_cmd(mk(OP_SAMPLE, 450, 0, 0, 0));
    send_cmd(mk(OP_SAMPLE, 0, 500, 0, 0));
    send_cmd(mk(OP_SAMPLE, 0, 0, 600, 0));
    send_cmd(mk(OP_SAMPLE, 2047, 0, 0, 0));
    send_cmd(mk(OP_MANUAL, 0, 0, 0, 255));
    send_cmd(mk(OP_MANUAL, 0, 0, 0, 0));
    send_cmd(mk(OP_MANUAL, 0, 0, 0, 101));
    send_cmd(mk(OP_MANUAL, 0, 0, 0, 100));
    send_cmd(mk(OP_UNUSED, -1, -1, -1, 255));
    send_cmd(mk(OP_SAMPLE, 416, 0, 0, 0));
    send_cmd(mk(OP_SAMPLE, 0, 480, 0, 0));
    send_cmd(mk(OP_SAMPLE, 0, 0, 481, 0));
    send_cmd(mk(OP_SAMPLE, 641, 0, 0, 0));
    send_cmd(mk(OP_SAMPLE, 415, 0, 0, 0));
    send_cmd(mk(OP_MANUAL, 0, 0, 0, 4));
    repeat (6) send_cmd(mk(OP_TICK, 0, 0, 0, 0));
    wait_all_status();

    // Random phases, each on a freshly written curve.
    for (int p = 0; p < PHASES; p++) begin
      set_curve(p);
      feed_gaps = (p == 1) || (p > 1 && $urandom_range(0, 2) != 0);
      sink_stalls = (p == 1) || (p > 1 && $urandom_range(0, 2) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the receiver off while items keep coming, so the input stalls.
        if (i == 20 && (p == 2 || p == 8)) begin
          saved_gaps = feed_gaps;
          feed_gaps = 1'b0;
          hold_cycles = LONG_HOLD;
          repeat (30) send_cmd(random_cmd());
          feed_gaps = saved_gaps;
        end
        if (i == 50 && p == 5) wait_all_status();
        send_cmd(random_cmd());
      end
      wait_all_status();
    end

    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.expected_status_q.size() == 0) begin
      $display("banded_fan_speed_pwm_core verification clean");
    end else begin
      $display("banded_fan_speed_pwm_core verification failed");
    end
    $finish;
  end

endmodule
